@@ src/assert_macros.svh @@
// Assertion macros shared by the encoder meter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/eswpm_pkg.sv @@
// Types and constants of the encoder slot width and period meter.
`timescale 1ns / 1ps
package eswpm_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PIN_SEL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_GOAL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_SLOTS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_US   = 2'd3;

	localparam logic [4:0]  RST_PIN_SEL     = 5'd2;
	localparam logic [15:0] RST_SLOT_GOAL   = 16'd20;
	localparam logic [7:0]  RST_WHEEL_SLOTS = 8'd20;
	localparam logic [15:0] RST_SETTLE_US   = 16'd1000;

	localparam int unsigned RPM_W = 26;
	localparam logic [RPM_W-1:0] RPM_NUMERATOR = 26'd60000000;
	localparam int unsigned DIVISOR_W = 40;
	localparam int unsigned DIV_STEPS = RPM_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [1:0] FLAG_FALL = 2'b01;
	localparam logic [1:0] FLAG_RISE = 2'b10;

	typedef struct packed {
		logic [4:0]  pin_number;
		logic [1:0]  edge_flags;
		logic [63:0] time_now;
	} event_t;

	typedef struct packed {
		logic [15:0]      slot_count;
		logic [31:0]      width_us;
		logic [31:0]      period_us;
		logic [63:0]      last_edge_time;
		logic             done_res;
		logic [RPM_W-1:0] speed_rpm;
	} result_t;

	typedef struct packed {
		logic [4:0]  pin_sel;
		logic [15:0] slot_goal;
		logic [7:0]  wheel_slots;
		logic [15:0] settle_us;
	} cfg_t;

	typedef struct packed {
		logic [15:0] slot_count;
		logic [31:0] width_us;
		logic [31:0] period_us;
		logic [63:0] last_edge_time;
		logic        done;
	} meas_t;

endpackage

@@ src/eswpm_event.sv @@
// Edge event filter and slot tracking state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module eswpm_event (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  eswpm_pkg::event_t item,
	input  eswpm_pkg::cfg_t  cfg,
	output eswpm_pkg::meas_t meas
);

	logic [15:0] count_q;
	logic [31:0] last_accept_q;
	logic [63:0] last_edge_q;
	logic [31:0] slot_open_q;
	logic [31:0] prior_start_q;
	logic        inside_slot_q;
	logic        prior_valid_q;
	logic [31:0] width_q;
	logic [31:0] period_q;

	logic [31:0] now;
	logic [31:0] since_accept;
	logic        take;
	logic        fall;
	logic        rise;
	logic [31:0] interval;

	assign now          = item.time_now[31:0];
	assign since_accept = now - last_accept_q;
	assign fall         = (item.edge_flags & eswpm_pkg::FLAG_FALL) != 2'b00;
	assign rise         = (item.edge_flags & eswpm_pkg::FLAG_RISE) != 2'b00;
	assign take         = (item.pin_number == cfg.pin_sel) &&
	                      (count_q < cfg.slot_goal) &&
	                      (since_accept > {16'd0, cfg.settle_us});
	// A falling edge measures the period, a rising edge the slot width.
	assign interval     = now - (fall ? prior_start_q : slot_open_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			last_accept_q <= '0;
			last_edge_q   <= '0;
			slot_open_q   <= '0;
			prior_start_q <= '0;
			inside_slot_q <= 1'b0;
			prior_valid_q <= 1'b0;
			width_q       <= '0;
			period_q      <= '0;
		end else if (fire && take) begin
			if (fall && rise) begin
				inside_slot_q <= 1'b0;
				prior_valid_q <= 1'b0;
			end else begin
				last_accept_q <= now;
				last_edge_q   <= item.time_now;
				if (fall) begin
					if (prior_valid_q) begin
						period_q <= interval;
					end
					prior_start_q <= now;
					prior_valid_q <= 1'b1;
					slot_open_q   <= now;
					inside_slot_q <= 1'b1;
				end else if (rise && inside_slot_q) begin
					width_q       <= interval;
					count_q       <= count_q + 16'd1;
					inside_slot_q <= 1'b0;
				end
			end
		end
	end

	assign meas.slot_count     = count_q;
	assign meas.width_us       = width_q;
	assign meas.period_us      = period_q;
	assign meas.last_edge_time = last_edge_q;
	assign meas.done           = count_q >= cfg.slot_goal;

	// Once the target is reached the count must freeze.
	`ASSERT_NEXT(a_count_frozen_at_target, fire && (count_q >= cfg.slot_goal), $stable(count_q))

endmodule

@@ src/eswpm_div.sv @@
// Radix-2 restoring divider of the rpm constant by the period product.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module eswpm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [eswpm_pkg::DIVISOR_W-1:0]     divisor,
	output logic                                done,
	output logic [eswpm_pkg::RPM_W-1:0]         quotient
);

	logic                                busy_q;
	logic                                done_q;
	logic                                zero_q;
	logic [eswpm_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [eswpm_pkg::DIVISOR_W-1:0]     dvs_q;
	logic [eswpm_pkg::RPM_W-1:0]         rem_q;
	logic [eswpm_pkg::RPM_W-1:0]         quo_q;

	logic [eswpm_pkg::RPM_W:0]           trial;
	logic [eswpm_pkg::DIVISOR_W-1:0]     trial_ext;
	logic [eswpm_pkg::DIVISOR_W-1:0]     diff;
	logic                                fits;

	// The next dividend bit comes from the top of the quotient register.
	assign trial     = {rem_q, quo_q[eswpm_pkg::RPM_W-1]};
	assign trial_ext = eswpm_pkg::DIVISOR_W'(trial);
	assign fits      = trial_ext >= dvs_q;
	assign diff      = trial_ext - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= eswpm_pkg::DIV_CNT_W'(eswpm_pkg::DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q  <= divisor;
			zero_q <= divisor == '0;
			rem_q  <= '0;
			quo_q  <= eswpm_pkg::RPM_NUMERATOR;
		end else if (busy_q) begin
			rem_q <= fits ? diff[eswpm_pkg::RPM_W-1:0] : trial[eswpm_pkg::RPM_W-1:0];
			quo_q <= {quo_q[eswpm_pkg::RPM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? '0 : quo_q;

	`ASSERT_SAME(a_done_not_busy, done_q, !busy_q)

endmodule

@@ src/encoder_slot_width_period_meter_unit.sv @@
// Top level of the encoder slot width and period meter.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// Edge events arrive on event_data with event_valid/event_ready; each accepted
// beat yields exactly one result beat on result with result_valid/result_ready.
// The result describes the tracking state after the event and carries the
// speed derived from the latest period and the slots-per-revolution setting.
// After an event is accepted, the sequencer steps through updating the slot
// state, the period times slots multiply, loading the divider, the restoring
// divider (one quotient bit per cycle for its 26 quotient bits), collecting the
// quotient and registering the result, which raises result_valid.
// The next event is taken only once the sequencer is back in idle, so no new
// event is accepted while the previous one is still being processed.
// event_ready is high only while the sequencer is idle. A finished result sits
// in the output register, so the next event can be taken while it waits.
// If the receiver stalls, a second finished result waits in the sequencer
// until the output register frees up, and no further event is taken.
// Configuration writes on cfg_we/cfg_index/cfg_wdata take effect at once and
// must only be made while idle. Reset loads default settings and clears all
// tracking state; the block is ready in the first cycle after reset.
module encoder_slot_width_period_meter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                event_valid,
	output logic                                event_ready,
	input  eswpm_pkg::event_t                   event_data,
	output logic                                result_valid,
	input  logic                                result_ready,
	output eswpm_pkg::result_t                  result,
	input  logic                                cfg_we,
	input  logic [eswpm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [eswpm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVENT = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DGO   = 3'd3;
	localparam logic [2:0] ST_DWAIT = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]                          state_q;
	eswpm_pkg::cfg_t                     cfg_q;
	eswpm_pkg::event_t                   item_q;
	logic [eswpm_pkg::DIVISOR_W-1:0]     divisor_q;
	logic [eswpm_pkg::RPM_W-1:0]         rpm_q;
	logic                                result_valid_q;
	eswpm_pkg::result_t                  result_q;

	eswpm_pkg::meas_t                    meas;
	logic                                div_done;
	logic [eswpm_pkg::RPM_W-1:0]         div_quotient;
	logic                                out_free;

	assign event_ready = state_q == ST_IDLE;
	assign out_free    = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pin_sel     <= eswpm_pkg::RST_PIN_SEL;
			cfg_q.slot_goal   <= eswpm_pkg::RST_SLOT_GOAL;
			cfg_q.wheel_slots <= eswpm_pkg::RST_WHEEL_SLOTS;
			cfg_q.settle_us   <= eswpm_pkg::RST_SETTLE_US;
		end else if (cfg_we) begin
			case (cfg_index)
				eswpm_pkg::CFG_PIN_SEL:     cfg_q.pin_sel     <= cfg_wdata[4:0];
				eswpm_pkg::CFG_SLOT_GOAL:   cfg_q.slot_goal   <= cfg_wdata;
				eswpm_pkg::CFG_WHEEL_SLOTS: cfg_q.wheel_slots <= cfg_wdata[7:0];
				eswpm_pkg::CFG_SETTLE_US:   cfg_q.settle_us   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (event_valid) begin
						state_q <= ST_EVENT;
					end
				end
				ST_EVENT: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_DGO;
				ST_DGO:   state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (event_valid && event_ready) begin
			item_q <= event_data;
		end
		if (state_q == ST_MUL) begin
			divisor_q <= eswpm_pkg::DIVISOR_W'(meas.period_us) *
			             eswpm_pkg::DIVISOR_W'(cfg_q.wheel_slots);
		end
		if (state_q == ST_DWAIT && div_done) begin
			rpm_q <= div_quotient;
		end
		if (state_q == ST_OUT && out_free) begin
			result_q.slot_count     <= meas.slot_count;
			result_q.width_us       <= meas.width_us;
			result_q.period_us      <= meas.period_us;
			result_q.last_edge_time <= meas.last_edge_time;
			result_q.done_res       <= meas.done;
			result_q.speed_rpm      <= rpm_q;
		end
	end

	eswpm_event u_event (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (state_q == ST_EVENT),
		.item   (item_q),
		.cfg    (cfg_q),
		.meas   (meas)
	);

	eswpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DGO),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_SAME(a_div_done_when_waiting, div_done, state_q == ST_DWAIT)
	`ASSERT_NEXT(a_result_loaded, (state_q == ST_OUT) && out_free, result_valid_q && (state_q == ST_IDLE))

endmodule

@@ test/encoder_slot_width_period_meter_unit_tb.sv @@
// Self-checking testbench for the encoder slot width and period meter.
`timescale 1ns / 1ps
module encoder_slot_width_period_meter_unit_tb;

	logic clk;
	logic arst_n;
	logic event_valid;
	logic event_ready;
	eswpm_pkg::event_t event_data;
	logic result_valid;
	logic result_ready;
	eswpm_pkg::result_t result;
	logic cfg_we;
	logic [eswpm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [eswpm_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// Settings as the block should hold them.
	logic [4:0] cur_pin;
	logic [15:0] cur_target;
	logic [7:0] cur_spr;
	logic [15:0] cur_debounce;

	// Slot tracking state mirrored from the block.
	logic [15:0] trk_count;
	logic [31:0] trk_last_accept;
	logic [63:0] trk_last_full;
	logic [31:0] trk_open;
	logic [31:0] trk_prior;
	logic trk_inside;
	logic trk_prior_ok;
	logic [31:0] trk_width;
	logic [31:0] trk_period;

	eswpm_pkg::result_t pending_results[$];
	int error_count = 0;

	// Sender pacing and receiver stall controls.
	int gap_max = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int hold_request = 0;
	int traffic_spread = 1000;
	logic [63:0] tb_clock;

	encoder_slot_width_period_meter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.event_valid(event_valid),
		.event_ready(event_ready),
		.event_data(event_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic clear_tracking();
		cur_pin = eswpm_pkg::RST_PIN_SEL;
		cur_target = eswpm_pkg::RST_SLOT_GOAL;
		cur_spr = eswpm_pkg::RST_WHEEL_SLOTS;
		cur_debounce = eswpm_pkg::RST_SETTLE_US;
		trk_count = '0;
		trk_last_accept = '0;
		trk_last_full = '0;
		trk_open = '0;
		trk_prior = '0;
		trk_inside = 1'b0;
		trk_prior_ok = 1'b0;
		trk_width = '0;
		trk_period = '0;
	endtask

	function automatic eswpm_pkg::result_t predict_meter_result(input eswpm_pkg::event_t ev);
		eswpm_pkg::result_t r;
		logic [31:0] now;
		logic [31:0] delta;
		logic [39:0] divisor;
		logic [63:0] quotient;
		now = ev.time_now[31:0];
		delta = now - trk_last_accept;
		if (ev.pin_number == cur_pin && trk_count < cur_target
				&& delta > {16'd0, cur_debounce}) begin
			if (ev.edge_flags == (eswpm_pkg::FLAG_FALL | eswpm_pkg::FLAG_RISE)) begin
				// Both edges at once: restart tracking, keep the debounce reference.
				trk_inside = 1'b0;
				trk_prior_ok = 1'b0;
			end else begin
				trk_last_accept = now;
				trk_last_full = ev.time_now;
				if ((ev.edge_flags & eswpm_pkg::FLAG_FALL) != 2'b00) begin
					if (trk_prior_ok)
						trk_period = now - trk_prior;
					trk_prior = now;
					trk_prior_ok = 1'b1;
					trk_open = now;
					trk_inside = 1'b1;
				end else if ((ev.edge_flags & eswpm_pkg::FLAG_RISE) != 2'b00
						&& trk_inside) begin
					trk_width = now - trk_open;
					trk_count = trk_count + 16'd1;
					trk_inside = 1'b0;
				end
			end
		end
		divisor = {8'd0, trk_period} * {32'd0, cur_spr};
		if (divisor != 40'd0)
			quotient = {38'd0, eswpm_pkg::RPM_NUMERATOR} / {24'd0, divisor};
		else
			quotient = 64'd0;
		r.slot_count = trk_count;
		r.width_us = trk_width;
		r.period_us = trk_period;
		r.last_edge_time = trk_last_full;
		r.done_res = (trk_count >= cur_target);
		r.speed_rpm = quotient[eswpm_pkg::RPM_W-1:0];
		return r;
	endfunction

	// Offers one event, waits for it to be taken and records the prediction.
	task automatic send_event(input logic [4:0] pin, input logic [1:0] flags,
			input logic [63:0] stamp);
		eswpm_pkg::event_t ev;
		ev.pin_number = pin;
		ev.edge_flags = flags;
		ev.time_now = stamp;
		event_valid <= 1'b1;
		event_data <= ev;
		do @(posedge clk); while (!event_ready);
		pending_results.push_back(predict_meter_result(ev));
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0 && gap_max > 0) begin
			event_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
	endtask

	task automatic wait_idle();
		event_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reg(input logic [eswpm_pkg::CFG_IDX_W-1:0] idx,
			input logic [eswpm_pkg::CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			eswpm_pkg::CFG_PIN_SEL: cur_pin = val[4:0];
			eswpm_pkg::CFG_SLOT_GOAL: cur_target = val;
			eswpm_pkg::CFG_WHEEL_SLOTS: cur_spr = val[7:0];
			eswpm_pkg::CFG_SETTLE_US: cur_debounce = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [4:0] pin, input logic [15:0] target,
			input logic [7:0] spr, input logic [15:0] debounce);
		write_reg(eswpm_pkg::CFG_PIN_SEL, {11'd0, pin});
		write_reg(eswpm_pkg::CFG_SLOT_GOAL, target);
		write_reg(eswpm_pkg::CFG_WHEEL_SLOTS, {8'd0, spr});
		write_reg(eswpm_pkg::CFG_SETTLE_US, debounce);
	endtask

	function automatic logic [63:0] next_stamp();
		tb_clock = tb_clock + 64'(cur_debounce) + 64'd1
			+ 64'($urandom_range(0, traffic_spread));
		return tb_clock;
	endfunction

	// Mostly clean fall/rise slots on the tracked pin, mixed with bounces,
	// restarts, stray edges, timer wraps and events from other pins.
	task automatic drive_encoder_traffic(input int n_items);
		int sent;
		int r;
		logic [63:0] stamp;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				send_event(cur_pin, eswpm_pkg::FLAG_FALL, next_stamp());
				sent++;
				if ($urandom_range(0, 5) == 0) begin
					send_event(cur_pin, 2'($urandom_range(0, 3)),
						tb_clock + 64'($urandom_range(0, cur_debounce)));
					sent++;
				end
				send_event(cur_pin, eswpm_pkg::FLAG_RISE, next_stamp());
				sent++;
			end else if (r < 73) begin
				send_event(cur_pin, eswpm_pkg::FLAG_FALL | eswpm_pkg::FLAG_RISE,
					next_stamp());
				sent++;
			end else if (r < 81) begin
				send_event(cur_pin, $urandom_range(0, 1) ? 2'b00 : eswpm_pkg::FLAG_RISE,
					next_stamp());
				sent++;
			end else if (r < 83) begin
				tb_clock = {tb_clock[63:32], 32'hFFFF_FFFF - $urandom_range(0, 5000)};
			end else if (r < 93) begin
				send_event(5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)),
					tb_clock + 64'($urandom_range(0, 2 * cur_debounce + 2)));
				sent++;
			end else begin
				stamp = {$urandom, $urandom};
				tb_clock = stamp;
				send_event(5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)), stamp);
				sent++;
			end
		end
	endtask

	task automatic test_directed();
		gap_max = 6;
		stall_mode = 1;
		send_event(5'd2, eswpm_pkg::FLAG_FALL, 64'd500);
		send_event(5'd2, eswpm_pkg::FLAG_FALL, 64'd1000);
		send_event(5'd3, eswpm_pkg::FLAG_FALL, 64'd5000);
		send_event(5'd2, 2'b00, 64'd5000);
		send_event(5'd2, eswpm_pkg::FLAG_RISE, 64'd7000);
		send_event(5'd2, eswpm_pkg::FLAG_FALL, 64'd9000);
		send_event(5'd2, eswpm_pkg::FLAG_RISE, 64'd9500);
		send_event(5'd2, eswpm_pkg::FLAG_RISE, 64'd12000);
		send_event(5'd2, eswpm_pkg::FLAG_FALL, 64'd20000);
		send_event(5'd2, eswpm_pkg::FLAG_FALL | eswpm_pkg::FLAG_RISE, 64'd25000);
		send_event(5'd2, eswpm_pkg::FLAG_FALL, 64'd25500);
		send_event(5'd2, eswpm_pkg::FLAG_FALL, 64'd27000);
		send_event(5'd2, eswpm_pkg::FLAG_RISE, 64'hABCD_0123_FFFF_F000);
		send_event(5'd2, eswpm_pkg::FLAG_FALL, 64'hFFFF_FFFF_0000_0200);
		send_event(5'd31, eswpm_pkg::FLAG_FALL | eswpm_pkg::FLAG_RISE,
			64'hFFFF_FFFF_FFFF_FFFF);
		send_event(5'd2, eswpm_pkg::FLAG_RISE, 64'd0);
	endtask

	task automatic test_config_extremes();
		logic [63:0] base;
		base = 64'h0000_0000_0001_0000;
		// Upper data bits beyond the register width must be dropped.
		write_reg(eswpm_pkg::CFG_PIN_SEL, 16'hFFFF);
		write_reg(eswpm_pkg::CFG_SETTLE_US, 16'd0);
		write_reg(eswpm_pkg::CFG_WHEEL_SLOTS, 16'd255);
		write_reg(eswpm_pkg::CFG_SLOT_GOAL, 16'hFFFF);
		send_event(5'd31, eswpm_pkg::FLAG_FALL, base);
		send_event(5'd31, eswpm_pkg::FLAG_RISE, base);
		send_event(5'd31, eswpm_pkg::FLAG_RISE, base + 64'd1);
		send_event(5'd31, eswpm_pkg::FLAG_FALL, base + 64'd2);
		send_event(5'd31, eswpm_pkg::FLAG_FALL, base + 64'd3);
		write_reg(eswpm_pkg::CFG_WHEEL_SLOTS, 16'd1);
		send_event(5'd31, eswpm_pkg::FLAG_FALL, base + 64'd4);
		write_reg(eswpm_pkg::CFG_WHEEL_SLOTS, 16'hFF00);
		send_event(5'd31, eswpm_pkg::FLAG_RISE, base + 64'd5);
		set_config(5'd0, 16'hFFFF, 8'd20, 16'hFFFF);
		send_event(5'd0, eswpm_pkg::FLAG_FALL, base + 64'd5 + 64'd65535);
		send_event(5'd0, eswpm_pkg::FLAG_FALL, base + 64'd5 + 64'd65536);
		write_reg(eswpm_pkg::CFG_SLOT_GOAL, 16'd0);
		send_event(5'd0, eswpm_pkg::FLAG_RISE, base + 64'd300000);
		write_reg(eswpm_pkg::CFG_SLOT_GOAL, 16'd1);
		send_event(5'd0, eswpm_pkg::FLAG_RISE, base + 64'd400000);
	endtask

	task automatic test_random_phase(input logic [4:0] pin, input logic [7:0] spr,
			input logic [15:0] debounce, input int spread, input int gaps,
			input int stalls, input int n_items);
		set_config(pin, 16'hFFFF, spr, debounce);
		traffic_spread = spread;
		gap_max = gaps;
		burst_left = 0;
		stall_mode = stalls;
		drive_encoder_traffic(n_items / 2);
		// Let the block drain completely before carrying on.
		wait_idle();
		drive_encoder_traffic(n_items - n_items / 2);
	endtask

	task automatic test_backpressure();
		set_config(5'd2, 16'hFFFF, 8'd20, 16'd100);
		traffic_spread = 3000;
		gap_max = 0;
		stall_mode = 0;
		wait_idle();
		hold_request = 400;
		drive_encoder_traffic(30);
	endtask

	task automatic test_done_flag();
		set_config(5'd7, trk_count + 16'd8, 8'd4, 16'd500);
		traffic_spread = 4000;
		gap_max = 20;
		stall_mode = 2;
		drive_encoder_traffic(60);
	endtask

	// Receiver ready pattern, with an optional long hold-off counted here.
	initial begin : ready_pattern
		int hold_left;
		int run_left;
		logic level;
		hold_left = 0;
		run_left = 0;
		level = 1'b0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (stall_mode == 0) begin
				result_ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					level = !level;
					if (stall_mode == 1)
						run_left = level ? $urandom_range(1, 12) : $urandom_range(1, 50);
					else
						run_left = level ? $urandom_range(1, 6) : $urandom_range(1, 3);
				end
				run_left--;
				result_ready <= level;
			end
		end
	end

	always @(posedge clk) begin : result_check
		eswpm_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no event pending");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.slot_count !== want.slot_count) begin
					$error("slot_count expected %0d actual %0d", want.slot_count,
						result.slot_count);
					error_count++;
				end
				if (result.width_us !== want.width_us) begin
					$error("width_us expected %0d actual %0d", want.width_us, result.width_us);
					error_count++;
				end
				if (result.period_us !== want.period_us) begin
					$error("period_us expected %0d actual %0d", want.period_us,
						result.period_us);
					error_count++;
				end
				if (result.last_edge_time !== want.last_edge_time) begin
					$error("last_edge_time expected %h actual %h", want.last_edge_time,
						result.last_edge_time);
					error_count++;
				end
				if (result.done_res !== want.done_res) begin
					$error("done_res expected %0d actual %0d", want.done_res, result.done_res);
					error_count++;
				end
				if (result.speed_rpm !== want.speed_rpm) begin
					$error("speed_rpm expected %0d actual %0d", want.speed_rpm,
						result.speed_rpm);
					error_count++;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		event_valid <= 1'b0;
		event_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		clear_tracking();
		tb_clock = {$urandom, 32'd0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_config_extremes();
		test_random_phase(5'd2, 8'd20, 16'd1000, 20000, 40, 1, 240);
		test_random_phase(5'd0, 8'd255, 16'd0, 200, 0, 0, 240);
		test_random_phase(5'd31, 8'd1, 16'hFFFF, 100000, 10, 1, 240);
		test_random_phase(5'($urandom_range(0, 31)), 8'($urandom_range(1, 255)),
			16'($urandom_range(0, 3000)), $urandom_range(100, 5000), 30, 2, 240);
		test_backpressure();
		test_done_flag();

		wait_idle();
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ encoder_slot_width_period_meter_unit.f @@
+incdir+src
src/eswpm_pkg.sv
src/eswpm_event.sv
src/eswpm_div.sv
src/encoder_slot_width_period_meter_unit.sv
test/encoder_slot_width_period_meter_unit_tb.sv
